// File: hdl/cpt_pkg.sv
// Shared types, register map and reset constants for the compressor protect timer.
package cpt_pkg;

    // Field widths
    localparam int unsigned CntW  = 16;
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    // Stream payload widths (padded to whole bytes)
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 56;

    // Reset values
    localparam logic [CntW-1:0] PROTECT_RELOAD_RST  = 16'd300;
    localparam logic [CntW-1:0] FIRST_ON_LIMIT_RST  = 16'd9000;
    localparam logic [CntW-1:0] SECOND_ON_LIMIT_RST = 16'd11400;
    localparam logic [CntW-1:0] TIME_CAP_RST        = 16'd60000;
    localparam logic [CntW-1:0] PROTECT_COUNT_RST   = 16'd300;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_FORCED_MODE     = 3'd0,
        REG_PROTECT_RELOAD  = 3'd1,
        REG_FIRST_ON_LIMIT  = 3'd2,
        REG_SECOND_ON_LIMIT = 3'd3,
        REG_TIME_CAP        = 3'd4,
        REG_ON_LIMIT_ENABLE = 3'd5
    } cpt_reg_idx_t;

    // Operation codes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } cpt_op_t;

    typedef struct packed {
        logic            forced_mode;
        logic [CntW-1:0] protect_reload;
        logic [CntW-1:0] first_on_limit;
        logic [CntW-1:0] second_on_limit;
        logic [CntW-1:0] time_cap;
        logic            on_limit_enable;
    } cpt_cfg_t;

    typedef struct packed {
        cpt_op_t         op;
        logic            cold_request;
        logic            ice_request;
        logic            forced_on;
        logic [CntW-1:0] load_value;
    } cpt_item_t;

    typedef struct packed {
        logic            compressor_on;
        logic            protect_expired;
        logic            over_first_limit;
        logic            over_second_limit;
        logic [CntW-1:0] on_seconds;
        logic [CntW-1:0] off_seconds;
        logic [CntW-1:0] protect_left;
    } cpt_result_t;

endpackage

// File: hdl/cpt_cfg.sv
// APB register file holding the timer configuration.
module cpt_cfg
    import cpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cpt_cfg_t         cfg
);

    cpt_cfg_t     cfg_reg;
    logic         wr_en;
    cpt_reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = cpt_reg_idx_t'(paddr[AddrW-1:2]);
    assign cfg    = cfg_reg;

    // Register writes; out-of-map indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forced_mode     <= 1'b0;
            cfg_reg.protect_reload  <= PROTECT_RELOAD_RST;
            cfg_reg.first_on_limit  <= FIRST_ON_LIMIT_RST;
            cfg_reg.second_on_limit <= SECOND_ON_LIMIT_RST;
            cfg_reg.time_cap        <= TIME_CAP_RST;
            cfg_reg.on_limit_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FORCED_MODE:     cfg_reg.forced_mode     <= pwdata[0];
                REG_PROTECT_RELOAD:  cfg_reg.protect_reload  <= pwdata[CntW-1:0];
                REG_FIRST_ON_LIMIT:  cfg_reg.first_on_limit  <= pwdata[CntW-1:0];
                REG_SECOND_ON_LIMIT: cfg_reg.second_on_limit <= pwdata[CntW-1:0];
                REG_TIME_CAP:        cfg_reg.time_cap        <= pwdata[CntW-1:0];
                REG_ON_LIMIT_ENABLE: cfg_reg.on_limit_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_FORCED_MODE:     prdata[0]        = cfg_reg.forced_mode;
            REG_PROTECT_RELOAD:  prdata[CntW-1:0] = cfg_reg.protect_reload;
            REG_FIRST_ON_LIMIT:  prdata[CntW-1:0] = cfg_reg.first_on_limit;
            REG_SECOND_ON_LIMIT: prdata[CntW-1:0] = cfg_reg.second_on_limit;
            REG_TIME_CAP:        prdata[CntW-1:0] = cfg_reg.time_cap;
            REG_ON_LIMIT_ENABLE: prdata[0]        = cfg_reg.on_limit_enable;
            default:             prdata           = '0;
        endcase
    end

endmodule

// File: hdl/cpt_core.sv
// Compressor state registers and the per-beat on/off, counter and countdown update.
module cpt_core
    import cpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  cpt_item_t   item,
    input  cpt_cfg_t    cfg,
    output cpt_result_t result
);

    logic            running_reg, running_next;
    logic [CntW-1:0] protect_count_reg, protect_count_next;
    logic [CntW-1:0] on_count_reg, on_count_next;
    logic [CntW-1:0] off_count_reg, off_count_next;

    logic            hold_off;
    logic            turn_on;
    logic [CntW-1:0] on_inc;
    logic [CntW-1:0] off_inc;
    logic [CntW-1:0] stop_base;

    // Saturating increments against the cap
    assign on_inc  = (on_count_reg  < cfg.time_cap) ? on_count_reg  + 1'b1 : on_count_reg;
    assign off_inc = (off_count_reg < cfg.time_cap) ? off_count_reg + 1'b1 : off_count_reg;

    // On/off decision: protection blocks a restart, forced mode overrides all
    assign hold_off  = !running_reg && (protect_count_reg != '0);
    assign turn_on   = cfg.forced_mode ? item.forced_on
                                       : ((item.cold_request || item.ice_request) && !hold_off);
    // Stop tick reloads before the countdown step
    assign stop_base = running_reg ? cfg.protect_reload : protect_count_reg;

    // Next state
    always_comb
    begin
        running_next       = running_reg;
        protect_count_next = protect_count_reg;
        on_count_next      = on_count_reg;
        off_count_next     = off_count_reg;
        if (item.op == OP_LOAD)
        begin
            protect_count_next = item.load_value;
        end
        else if (turn_on)
        begin
            running_next       = 1'b1;
            on_count_next      = on_inc;
            off_count_next     = '0;
            protect_count_next = cfg.protect_reload;
        end
        else
        begin
            running_next       = 1'b0;
            on_count_next      = '0;
            off_count_next     = off_inc;
            protect_count_next = (stop_base != '0) ? stop_base - 1'b1 : stop_base;
        end
    end

    // Result reflects the state after this beat
    always_comb
    begin
        result.compressor_on     = running_next;
        result.protect_expired   = running_next || (protect_count_next == '0);
        result.over_first_limit  = cfg.on_limit_enable && (on_count_next > cfg.first_on_limit);
        result.over_second_limit = cfg.on_limit_enable && (on_count_next > cfg.second_on_limit);
        result.on_seconds        = on_count_next;
        result.off_seconds       = off_count_next;
        result.protect_left      = protect_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            protect_count_reg <= PROTECT_COUNT_RST;
            on_count_reg      <= '0;
            off_count_reg     <= '0;
        end
        else if (step)
        begin
            running_reg       <= running_next;
            protect_count_reg <= protect_count_next;
            on_count_reg      <= on_count_next;
            off_count_reg     <= off_count_next;
        end
    end

    // A stopped compressor never carries on time
    a_off_no_on_time: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> on_count_reg == '0)
        else $error("on time nonzero while stopped");

    // A running compressor never carries off time
    a_on_no_off_time: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> off_count_reg == '0)
        else $error("off time nonzero while running");

    // A load beat leaves run state and both time counters alone
    a_load_keeps_timers: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.op == OP_LOAD |=>
            $stable(running_reg) && $stable(on_count_reg) && $stable(off_count_reg))
        else $error("load beat disturbed run state");

endmodule

// File: hdl/compressor_protect_timer_unit.sv
// Top level: stream ports, input and result registers around the timer core.
// Each beat is held in the input register, then its result is held in the result register.
// Throughput: one beat per cycle while m_axis_tready is high, via cpt_core's update;
// with both registers full, s_axis_tready follows m_axis_tready in the same cycle.
// Reset (rst_n low, asynchronous): pipeline empties, compressor off, countdown 300,
// time counters zero, configuration registers return to their defaults.
module compressor_protect_timer_unit
    import cpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input beat stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] cold_request, [1] ice_request, [2] forced_on, [18:3] load_value, rest zero
    input  logic [InDataW-1:0]  s_axis_tdata,
    // [0] op
    input  logic                s_axis_tuser,
    // Result beat stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] compressor_on, [1] protect_expired, [2] over_first_limit,
    // [3] over_second_limit, [19:4] on_seconds, [35:20] off_seconds,
    // [51:36] protect_left, rest zero
    output logic [OutDataW-1:0] m_axis_tdata,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready
);

    cpt_cfg_t    cfg;
    cpt_item_t   in_item_reg;
    logic        in_valid_reg;
    cpt_result_t core_result;
    cpt_result_t out_result_reg;
    logic        out_valid_reg;
    logic        s_accept;
    logic        advance;

    cpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Handshake: the held beat moves on when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.op           <= cpt_op_t'(s_axis_tuser);
            in_item_reg.cold_request <= s_axis_tdata[0];
            in_item_reg.ice_request  <= s_axis_tdata[1];
            in_item_reg.forced_on    <= s_axis_tdata[2];
            in_item_reg.load_value   <= s_axis_tdata[CntW+2:3];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(OutDataW - 4 - 3*CntW){1'b0}},
        out_result_reg.protect_left,
        out_result_reg.off_seconds,
        out_result_reg.on_seconds,
        out_result_reg.over_second_limit,
        out_result_reg.over_first_limit,
        out_result_reg.protect_expired,
        out_result_reg.compressor_on
    };

    // A stalled result with a held input beat must block the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline full");

    // An empty input register always takes a beat
    a_empty_takes_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input blocked while empty");

    // A beat that moves into the core produces a result beat next cycle
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result beat missing after advance");

endmodule
